FILE: hdl/bgid_pkg.sv
package bgid_pkg;

  // geometry of the identifier and the board
  localparam int SEXTETS     = 14;
  localparam int SEXTET_BITS = 6;
  localparam int STREAM_BITS = SEXTETS * SEXTET_BITS;
  localparam int KEY_BITS    = 80;
  localparam int POINTS      = 25;
  localparam int BOARD_PTS   = 2 * POINTS;

  typedef logic [SEXTET_BITS-1:0] sextet_t;
  typedef logic [4:0]             count_t;
  typedef logic [4:0]             point_t;
  typedef logic [1:0]             status_t;
  typedef logic [5:0]             addr_t;

  localparam count_t CNT_MAX = 5'd31;

  // result status codes
  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_BAD_CHAR   = 2'd1;
  localparam status_t STATUS_INCOMPLETE = 2'd2;

  // one access to the point count memory
  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    count_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic    bad;
    sextet_t value;
  } char_map_t;

  // base64 alphabet lookup, bad set for anything outside it
  function automatic char_map_t map_char(input logic [7:0] c);
    char_map_t  res;
    logic [7:0] tmp;
    res = '0;
    tmp = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      tmp = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      tmp = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      tmp = c + 8'd4;
    end else if (c == 8'h2B) begin
      tmp = 8'd62;
    end else if (c == 8'h2F) begin
      tmp = 8'd63;
    end else begin
      res.bad = 1'b1;
    end
    res.value = tmp[SEXTET_BITS-1:0];
    return res;
  endfunction

endpackage

FILE: hdl/backgammon_position_id_decoder.sv
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall | id_char, final_char
// out_    | output    | out_valid/out_stall | side, point_number, checkers, status, end_of_board
//
// characters are taken while in_stall is low; after the final one the key is walked one bit a cycle,
// then the 50 counts leave through the count memory read port, each read in ST_RD and loaded
// into the output register in ST_LD.
// an error result is loaded into the output register from ST_ERR once that register is free.
// rst_n is synchronous; reset empties the output register and the character store.
// out_stall holds the output register and pauses the walk over the memory; in_stall is high
// from the final character until the last result sits in the output register.
module backgammon_position_id_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_id_char,
  input  logic               in_final_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_side,
  output bgid_pkg::point_t   out_point_number,
  output bgid_pkg::count_t   out_checkers,
  output bgid_pkg::status_t  out_status,
  output logic               out_end_of_board
);
  import bgid_pkg::*;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_ERR    = 3'd2;
  localparam logic [2:0] ST_RD     = 3'd3;
  localparam logic [2:0] ST_LD     = 3'd4;

  logic [2:0]          state_r;
  logic [6:0]          bit_idx_r;
  logic                player_r;
  point_t              point_r;
  count_t              cnt_r;
  status_t             err_r;

  logic                out_valid_r;
  logic                out_side_r;
  point_t              out_point_r;
  count_t              out_checkers_r;
  status_t             out_status_r;
  logic                out_eob_r;

  logic [KEY_BITS-1:0] key_bits;
  logic                bad_seen;
  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                clear;
  logic [6:0]          key_sel;
  logic                key_bit;
  logic                last_pt;
  addr_t               addr;
  ram_req_t            ram_req;
  count_t              rd_data;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((state_r == ST_ERR) || (state_r == ST_LD));
  assign last_pt  = player_r && (point_r == point_t'(POINTS-1));

  // key bytes are read lsb first over an msb-first stream
  assign key_sel = {bit_idx_r[6:3], ~bit_idx_r[2:0]};
  assign key_bit = key_bits[key_sel];
  assign addr    = player_r ? (addr_t'(point_r) + addr_t'(POINTS)) : addr_t'(point_r);

  assign clear = out_free && ((state_r == ST_ERR) || (state_r == ST_LD && last_pt));

  bgid_sextet_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .id_char  (in_id_char),
    .clear    (clear),
    .key_bits (key_bits),
    .bad_seen (bad_seen)
  );

  // memory traffic: count write on a point advance, read while emitting
  always_comb begin
    ram_req = '0;
    if (state_r == ST_DECODE && !bad_seen && !key_bit) begin
      ram_req.wr_en   = 1'b1;
      ram_req.wr_addr = addr;
      ram_req.wr_data = cnt_r;
    end
    if (state_r == ST_RD) begin
      ram_req.rd_en   = 1'b1;
      ram_req.rd_addr = addr;
    end
  end

  bgid_count_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // sequencer: load, walk the key bits, then report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      bit_idx_r   <= '0;
      player_r    <= 1'b0;
      point_r     <= '0;
      cnt_r       <= '0;
      err_r       <= STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc && in_final_char) begin
            state_r   <= ST_DECODE;
            bit_idx_r <= '0;
            player_r  <= 1'b0;
            point_r   <= '0;
            cnt_r     <= '0;
          end
        end
        ST_DECODE: begin
          if (bad_seen) begin
            err_r   <= STATUS_BAD_CHAR;
            state_r <= ST_ERR;
          end else begin
            bit_idx_r <= bit_idx_r + 7'd1;
            if (key_bit) begin
              if (cnt_r != CNT_MAX) begin
                cnt_r <= cnt_r + 5'd1;
              end
            end else begin
              cnt_r <= '0;
              if (point_r == point_t'(POINTS-1)) begin
                point_r  <= '0;
                player_r <= ~player_r;
              end else begin
                point_r <= point_r + 5'd1;
              end
            end
            if (!key_bit && last_pt) begin
              state_r <= ST_RD;
            end else if (bit_idx_r == 7'(KEY_BITS-1)) begin
              err_r   <= STATUS_INCOMPLETE;
              state_r <= ST_ERR;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_side_r     <= 1'b0;
            out_point_r    <= '0;
            out_checkers_r <= '0;
            out_status_r   <= err_r;
            out_eob_r      <= 1'b1;
            state_r        <= ST_LOAD;
          end
        end
        ST_RD: begin
          state_r <= ST_LD;
        end
        ST_LD: begin
          if (out_free) begin
            out_side_r     <= player_r;
            out_point_r    <= point_r;
            out_checkers_r <= rd_data;
            out_status_r   <= STATUS_OK;
            out_eob_r      <= last_pt;
            if (last_pt) begin
              state_r <= ST_LOAD;
            end else begin
              state_r <= ST_RD;
              if (point_r == point_t'(POINTS-1)) begin
                point_r  <= '0;
                player_r <= 1'b1;
              end else begin
                point_r <= point_r + 5'd1;
              end
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_side         = out_side_r;
  assign out_point_number = out_point_r;
  assign out_checkers     = out_checkers_r;
  assign out_status       = out_status_r;
  assign out_end_of_board = out_eob_r;

  // count writes stay inside the board
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> (ram_req.wr_addr < addr_t'(BOARD_PTS)))
    else $error("count write outside the board");

  // point counter never passes the last point of a side
  a_point_range: assert property (@(posedge clk) disable iff (!rst_n)
    point_r <= point_t'(POINTS-1))
    else $error("point counter out of range");

  // the key walk never reads past the key
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECODE) |-> (bit_idx_r < 7'(KEY_BITS)))
    else $error("key walk past the last bit");

  // an error result is always the only and last beat
  a_err_eob: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK) |-> out_eob_r)
    else $error("error beat without end of board");

endmodule

FILE: hdl/bgid_sextet_store.sv
module bgid_sextet_store (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [7:0]                         id_char,
  input  logic                               clear,
  output logic [bgid_pkg::KEY_BITS-1:0]      key_bits,
  output logic                               bad_seen
);
  import bgid_pkg::*;

  sextet_t                sextet_r [SEXTETS];
  logic [3:0]             char_cnt_r;
  logic                   bad_r;
  char_map_t              mapped;
  logic [STREAM_BITS-1:0] stream;

  assign mapped = map_char(id_char);

  // store the first characters as sextets, later ones dropped unchecked
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      char_cnt_r <= 4'd0;
      bad_r      <= 1'b0;
      for (int i = 0; i < SEXTETS; i++) begin
        sextet_r[i] <= '0;
      end
    end else if (wr_en && char_cnt_r < 4'(SEXTETS)) begin
      char_cnt_r <= char_cnt_r + 4'd1;
      if (mapped.bad) begin
        bad_r <= 1'b1;
      end
      for (int i = 0; i < SEXTETS; i++) begin
        if (char_cnt_r == 4'(i)) begin
          sextet_r[i] <= mapped.bad ? '0 : mapped.value;
        end
      end
    end
  end

  // bit stream, position 0 is the msb of the first sextet
  always_comb begin
    stream = '0;
    for (int i = 0; i < SEXTETS; i++) begin
      for (int m = 0; m < SEXTET_BITS; m++) begin
        stream[SEXTET_BITS*i + SEXTET_BITS-1 - m] = sextet_r[i][m];
      end
    end
  end

  assign key_bits = stream[KEY_BITS-1:0];
  assign bad_seen = bad_r;

endmodule

FILE: hdl/bgid_count_ram.sv
module bgid_count_ram (
  input  logic               clk,
  input  bgid_pkg::ram_req_t req,
  output bgid_pkg::count_t   rd_data
);
  import bgid_pkg::*;

  count_t mem [BOARD_PTS];
  count_t rd_data_r;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
